>>> rtl/rau_pkg.sv
package rau_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DEN_W  = 63;
  localparam int unsigned PROD_W = 2 * WORD_W;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_SUB = 3'd1;
  localparam logic [2:0] REQ_MUL = 3'd2;
  localparam logic [2:0] REQ_DIV = 3'd3;
  localparam logic [2:0] REQ_CMP = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_DIV0 = 2'd2;

  localparam logic [1:0] ORDER_LT = 2'd0;
  localparam logic [1:0] ORDER_EQ = 2'd1;
  localparam logic [1:0] ORDER_GT = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [WORD_W-1:0] a_num;
    logic [DEN_W-1:0]         a_den;
    logic signed [WORD_W-1:0] b_num;
    logic [DEN_W-1:0]         b_den;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_num;
    logic [DEN_W-1:0]         res_den;
    logic [1:0]               status;
    logic [1:0]               order;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } unit_op_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] value;
  } unit_res_t;

  typedef enum logic [1:0] {
    GCD_IDLE,
    GCD_RUN,
    GCD_SHIFT
  } gcd_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_GCD,
    S_ADD_DIVX,
    S_ADD_DIVY,
    S_ADD_MULP,
    S_ADD_MULQ,
    S_ADD_MULD,
    S_ADD_SUM,
    S_ADD_GCD2,
    S_ADD_DIVN,
    S_ADD_DIVD,
    S_MUL_GCD1,
    S_MUL_DIVXN,
    S_MUL_DIVYD,
    S_MUL_GCD2,
    S_MUL_DIVXD,
    S_MUL_DIVYN,
    S_MUL_MULN,
    S_MUL_MULD,
    S_CMP_MULL,
    S_CMP_MULR,
    S_FINISH
  } seq_state_t;

endpackage

>>> rtl/rational_arith_unit_top.sv
// Path from accept to res_valid: unused codes and operand errors go straight to finish,
// compare runs two multiplies, multiply/divide and add/subtract run their unit passes;
// their time varies with the operands, mostly from the two binary gcd runs.
// Throughput: one request at a time; the next is taken once the result is loaded.
// Each divide or multiply pass holds the sequencer until that unit reports done.
// Reset: synchronous, active high; returns to idle and drops any pending result.
module rational_arith_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rau_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output rau_pkg::rsp_t res_data
);

  localparam logic [rau_pkg::WORD_W-1:0] SIGN_MIN = {1'b1, {(rau_pkg::WORD_W-1){1'b0}}};

  rau_pkg::seq_state_t state, state_next;
  logic launched;

  logic [rau_pkg::WORD_W-1:0] xn, xd, yn, yd, cx, cy, p, q, dd, nm, gg;
  logic                       xs, ys, ns, sub_op;
  logic [rau_pkg::PROD_W-1:0] wide;
  logic [rau_pkg::WORD_W-1:0] fin_num;
  logic [rau_pkg::DEN_W-1:0]  fin_den;
  logic [1:0]                 fin_status, fin_order;

  rau_pkg::unit_op_t  gcd_op, div_op, mul_op;
  rau_pkg::unit_res_t gcd_res, div_res, mul_res;

  logic                       accept, load;
  logic                       a_neg, b_neg, den_zero;
  logic [rau_pkg::WORD_W-1:0] a_mag, b_mag, ad64, bd64;
  logic [rau_pkg::WORD_W-1:0] s_yn, s_yd;
  rau_pkg::seq_state_t        entry;
  logic [1:0]                 entry_status, entry_order;
  logic                       mul_neg, mul_ovf;
  logic [rau_pkg::WORD_W-1:0] mul_val, sum, sum_mag, lo;
  logic                       sum_ovf, is_gcd, is_div, is_mul;
  logic                       cmp_lt, cmp_eq;

  rau_gcd u_gcd (.clk(clk), .rst(rst), .op(gcd_op), .res(gcd_res));
  rau_div u_div (.clk(clk), .rst(rst), .op(div_op), .res(div_res));
  rau_mul u_mul (.clk(clk), .rst(rst), .op(mul_op), .res(mul_res));

  assign req_ready = (state == rau_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign load      = (state == rau_pkg::S_FINISH) && (!res_valid || res_ready);

  assign a_neg    = req_data.a_num[rau_pkg::WORD_W-1];
  assign b_neg    = req_data.b_num[rau_pkg::WORD_W-1];
  assign a_mag    = a_neg ? -req_data.a_num : req_data.a_num;
  assign b_mag    = b_neg ? -req_data.b_num : req_data.b_num;
  assign ad64     = {1'b0, req_data.a_den};
  assign bd64     = {1'b0, req_data.b_den};
  assign den_zero = (req_data.a_den == '0) || (req_data.b_den == '0);
  assign s_yn     = (req_data.req_type == rau_pkg::REQ_DIV) ? bd64 : b_mag;
  assign s_yd     = (req_data.req_type == rau_pkg::REQ_DIV) ? b_mag : bd64;

  always_comb begin
    entry        = rau_pkg::S_FINISH;
    entry_status = rau_pkg::STATUS_OK;
    entry_order  = rau_pkg::ORDER_LT;
    priority if (req_data.req_type > rau_pkg::REQ_CMP) begin
      entry = rau_pkg::S_FINISH;
    end else if (den_zero) begin
      entry_status = rau_pkg::STATUS_DIV0;
    end else if (req_data.req_type == rau_pkg::REQ_ADD ||
                 req_data.req_type == rau_pkg::REQ_SUB) begin
      entry = rau_pkg::S_ADD_GCD;
    end else if (req_data.req_type == rau_pkg::REQ_MUL) begin
      if (req_data.a_num != '0 && req_data.b_num != '0) entry = rau_pkg::S_MUL_GCD1;
    end else if (req_data.req_type == rau_pkg::REQ_DIV) begin
      priority if (req_data.b_num == '0) begin
        entry_status = rau_pkg::STATUS_DIV0;
      end else if (req_data.b_num == SIGN_MIN) begin
        entry_status = rau_pkg::STATUS_OVF;
      end else if (req_data.a_num != '0) begin
        entry = rau_pkg::S_MUL_GCD1;
      end
    end else begin
      if (a_neg != b_neg) begin
        entry_order = a_neg ? rau_pkg::ORDER_LT : rau_pkg::ORDER_GT;
      end else begin
        entry = rau_pkg::S_CMP_MULL;
      end
    end
  end

  always_comb begin
    mul_neg = 1'b0;
    unique case (state)
      rau_pkg::S_ADD_MULP: mul_neg = xs;
      rau_pkg::S_ADD_MULQ: mul_neg = ys;
      rau_pkg::S_MUL_MULN: mul_neg = xs ^ ys;
      default:             mul_neg = 1'b0;
    endcase
    lo = mul_res.value[rau_pkg::WORD_W-1:0];
    if (mul_res.value[rau_pkg::PROD_W-1:rau_pkg::WORD_W] != '0) begin
      mul_ovf = 1'b1;
    end else if (mul_neg) begin
      mul_ovf = lo > SIGN_MIN;
    end else begin
      mul_ovf = lo[rau_pkg::WORD_W-1];
    end
    mul_val = mul_neg ? -lo : lo;
  end

  assign sum     = sub_op ? (p - q) : (p + q);
  assign sum_ovf = (sub_op ? (p[rau_pkg::WORD_W-1] != q[rau_pkg::WORD_W-1])
                           : (p[rau_pkg::WORD_W-1] == q[rau_pkg::WORD_W-1])) &&
                   (sum[rau_pkg::WORD_W-1] != p[rau_pkg::WORD_W-1]);
  assign sum_mag = sum[rau_pkg::WORD_W-1] ? -sum : sum;
  assign cmp_lt  = wide < mul_res.value;
  assign cmp_eq  = wide == mul_res.value;

  always_comb begin
    is_gcd   = 1'b0;
    is_div   = 1'b0;
    is_mul   = 1'b0;
    gcd_op.a = xd;
    gcd_op.b = yd;
    div_op.a = xd;
    div_op.b = gg;
    mul_op.a = xn;
    mul_op.b = yd;
    unique case (state)
      rau_pkg::S_ADD_GCD:   is_gcd = 1'b1;
      rau_pkg::S_ADD_GCD2:  begin is_gcd = 1'b1; gcd_op.a = nm; gcd_op.b = dd; end
      rau_pkg::S_MUL_GCD1:  begin is_gcd = 1'b1; gcd_op.a = xn; gcd_op.b = yd; end
      rau_pkg::S_MUL_GCD2:  begin is_gcd = 1'b1; gcd_op.a = xd; gcd_op.b = yn; end
      rau_pkg::S_ADD_DIVX:  is_div = 1'b1;
      rau_pkg::S_ADD_DIVY:  begin is_div = 1'b1; div_op.a = yd; end
      rau_pkg::S_ADD_DIVN:  begin is_div = 1'b1; div_op.a = nm; end
      rau_pkg::S_ADD_DIVD:  begin is_div = 1'b1; div_op.a = dd; end
      rau_pkg::S_MUL_DIVXN: begin is_div = 1'b1; div_op.a = xn; end
      rau_pkg::S_MUL_DIVYD: begin is_div = 1'b1; div_op.a = yd; end
      rau_pkg::S_MUL_DIVXD: begin is_div = 1'b1; div_op.a = xd; end
      rau_pkg::S_MUL_DIVYN: begin is_div = 1'b1; div_op.a = yn; end
      rau_pkg::S_ADD_MULP:  begin is_mul = 1'b1; mul_op.a = xn; mul_op.b = cy; end
      rau_pkg::S_ADD_MULQ:  begin is_mul = 1'b1; mul_op.a = yn; mul_op.b = cx; end
      rau_pkg::S_ADD_MULD:  begin is_mul = 1'b1; mul_op.a = xd; mul_op.b = cy; end
      rau_pkg::S_MUL_MULN:  begin is_mul = 1'b1; mul_op.a = xn; mul_op.b = yn; end
      rau_pkg::S_MUL_MULD:  begin is_mul = 1'b1; mul_op.a = xd; mul_op.b = yd; end
      rau_pkg::S_CMP_MULL:  begin is_mul = 1'b1; mul_op.a = xn; mul_op.b = yd; end
      rau_pkg::S_CMP_MULR:  begin is_mul = 1'b1; mul_op.a = yn; mul_op.b = xd; end
      default:              is_mul = 1'b0;
    endcase
    gcd_op.start = is_gcd && !launched;
    div_op.start = is_div && !launched;
    mul_op.start = is_mul && !launched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rau_pkg::S_IDLE;
      launched  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (gcd_op.start || div_op.start || mul_op.start) begin
        launched <= 1'b1;
      end else if (gcd_res.done || div_res.done || mul_res.done) begin
        launched <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE:      if (accept) state_next = entry;
      rau_pkg::S_ADD_GCD:   if (gcd_res.done) state_next = rau_pkg::S_ADD_DIVX;
      rau_pkg::S_ADD_DIVX:  if (div_res.done) state_next = rau_pkg::S_ADD_DIVY;
      rau_pkg::S_ADD_DIVY:  if (div_res.done) state_next = rau_pkg::S_ADD_MULP;
      rau_pkg::S_ADD_MULP: begin
        if (mul_res.done) state_next = mul_ovf ? rau_pkg::S_FINISH : rau_pkg::S_ADD_MULQ;
      end
      rau_pkg::S_ADD_MULQ: begin
        if (mul_res.done) state_next = mul_ovf ? rau_pkg::S_FINISH : rau_pkg::S_ADD_MULD;
      end
      rau_pkg::S_ADD_MULD: begin
        if (mul_res.done) state_next = mul_ovf ? rau_pkg::S_FINISH : rau_pkg::S_ADD_SUM;
      end
      rau_pkg::S_ADD_SUM: begin
        state_next = (sum_ovf || sum == '0) ? rau_pkg::S_FINISH : rau_pkg::S_ADD_GCD2;
      end
      rau_pkg::S_ADD_GCD2:  if (gcd_res.done) state_next = rau_pkg::S_ADD_DIVN;
      rau_pkg::S_ADD_DIVN:  if (div_res.done) state_next = rau_pkg::S_ADD_DIVD;
      rau_pkg::S_ADD_DIVD:  if (div_res.done) state_next = rau_pkg::S_FINISH;
      rau_pkg::S_MUL_GCD1:  if (gcd_res.done) state_next = rau_pkg::S_MUL_DIVXN;
      rau_pkg::S_MUL_DIVXN: if (div_res.done) state_next = rau_pkg::S_MUL_DIVYD;
      rau_pkg::S_MUL_DIVYD: if (div_res.done) state_next = rau_pkg::S_MUL_GCD2;
      rau_pkg::S_MUL_GCD2:  if (gcd_res.done) state_next = rau_pkg::S_MUL_DIVXD;
      rau_pkg::S_MUL_DIVXD: if (div_res.done) state_next = rau_pkg::S_MUL_DIVYN;
      rau_pkg::S_MUL_DIVYN: if (div_res.done) state_next = rau_pkg::S_MUL_MULN;
      rau_pkg::S_MUL_MULN: begin
        if (mul_res.done) state_next = mul_ovf ? rau_pkg::S_FINISH : rau_pkg::S_MUL_MULD;
      end
      rau_pkg::S_MUL_MULD:  if (mul_res.done) state_next = rau_pkg::S_FINISH;
      rau_pkg::S_CMP_MULL:  if (mul_res.done) state_next = rau_pkg::S_CMP_MULR;
      rau_pkg::S_CMP_MULR:  if (mul_res.done) state_next = rau_pkg::S_FINISH;
      rau_pkg::S_FINISH:    if (load) state_next = rau_pkg::S_IDLE;
      default:              state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data.res_num <= fin_num;
      res_data.res_den <= fin_den;
      res_data.status  <= fin_status;
      res_data.order   <= fin_order;
    end
    if (gcd_res.done) gg <= gcd_res.value[rau_pkg::WORD_W-1:0];
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (accept) begin
          xn         <= a_mag;
          xs         <= a_neg;
          xd         <= ad64;
          yn         <= s_yn;
          ys         <= b_neg;
          yd         <= s_yd;
          sub_op     <= (req_data.req_type == rau_pkg::REQ_SUB);
          fin_num    <= '0;
          fin_den    <= {{(rau_pkg::DEN_W-1){1'b0}}, 1'b1};
          fin_status <= entry_status;
          fin_order  <= entry_order;
        end
      end
      rau_pkg::S_ADD_DIVX:  if (div_res.done) cx <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_ADD_DIVY:  if (div_res.done) cy <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_ADD_DIVN:  if (div_res.done) nm <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_MUL_DIVXN: if (div_res.done) xn <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_MUL_DIVYD: if (div_res.done) yd <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_MUL_DIVXD: if (div_res.done) xd <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_MUL_DIVYN: if (div_res.done) yn <= div_res.value[rau_pkg::WORD_W-1:0];
      rau_pkg::S_ADD_DIVD: begin
        if (div_res.done) begin
          fin_num <= ns ? -nm : nm;
          fin_den <= div_res.value[rau_pkg::DEN_W-1:0];
        end
      end
      rau_pkg::S_ADD_MULP: begin
        if (mul_res.done) begin
          p <= mul_val;
          if (mul_ovf) fin_status <= rau_pkg::STATUS_OVF;
        end
      end
      rau_pkg::S_ADD_MULQ: begin
        if (mul_res.done) begin
          q <= mul_val;
          if (mul_ovf) fin_status <= rau_pkg::STATUS_OVF;
        end
      end
      rau_pkg::S_ADD_MULD: begin
        if (mul_res.done) begin
          dd <= mul_val;
          if (mul_ovf) fin_status <= rau_pkg::STATUS_OVF;
        end
      end
      rau_pkg::S_ADD_SUM: begin
        nm <= sum_mag;
        ns <= sum[rau_pkg::WORD_W-1];
        if (sum_ovf) fin_status <= rau_pkg::STATUS_OVF;
      end
      rau_pkg::S_MUL_MULN: begin
        if (mul_res.done) begin
          p <= mul_val;
          if (mul_ovf) fin_status <= rau_pkg::STATUS_OVF;
        end
      end
      rau_pkg::S_MUL_MULD: begin
        if (mul_res.done) begin
          if (mul_ovf) begin
            fin_status <= rau_pkg::STATUS_OVF;
          end else begin
            fin_num <= p;
            fin_den <= mul_val[rau_pkg::DEN_W-1:0];
          end
        end
      end
      rau_pkg::S_CMP_MULL: if (mul_res.done) wide <= mul_res.value;
      rau_pkg::S_CMP_MULR: begin
        if (mul_res.done) begin
          if (cmp_eq) begin
            fin_order <= rau_pkg::ORDER_EQ;
          end else if (cmp_lt != xs) begin
            fin_order <= rau_pkg::ORDER_LT;
          end else begin
            fin_order <= rau_pkg::ORDER_GT;
          end
        end
      end
      default: sub_op <= sub_op;
    endcase
  end

endmodule

>>> rtl/rau_gcd.sv
module rau_gcd (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::unit_op_t op,
  output rau_pkg::unit_res_t res
);

  rau_pkg::gcd_state_t state, state_next;
  logic [rau_pkg::WORD_W-1:0] u;
  logic [rau_pkg::WORD_W-1:0] v;
  logic [6:0]                 k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::GCD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res.done   = 1'b0;
    res.value  = {{rau_pkg::WORD_W{1'b0}}, u};
    unique case (state)
      rau_pkg::GCD_IDLE: begin
        if (op.start) state_next = rau_pkg::GCD_RUN;
      end
      rau_pkg::GCD_RUN: begin
        if (u == '0 || v == '0) state_next = rau_pkg::GCD_SHIFT;
      end
      rau_pkg::GCD_SHIFT: begin
        if (k == '0) begin
          res.done   = 1'b1;
          state_next = rau_pkg::GCD_IDLE;
        end
      end
      default: state_next = rau_pkg::GCD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::GCD_IDLE: begin
        u <= op.a;
        v <= op.b;
        k <= '0;
      end
      rau_pkg::GCD_RUN: begin
        priority if (u == '0) begin
          u <= v;
        end else if (v == '0) begin
          u <= u;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 7'd1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      rau_pkg::GCD_SHIFT: begin
        if (k != '0) begin
          u <= u << 1;
          k <= k - 7'd1;
        end
      end
      default: u <= u;
    endcase
  end

endmodule

>>> rtl/rau_div.sv
module rau_div (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::unit_op_t op,
  output rau_pkg::unit_res_t res
);

  logic                       busy;
  logic                       done;
  logic [5:0]                 cnt;
  logic [rau_pkg::WORD_W-1:0] rem;
  logic [rau_pkg::WORD_W-1:0] quo;
  logic [rau_pkg::WORD_W-1:0] dvs;
  logic [rau_pkg::WORD_W:0]   shifted;
  logic [rau_pkg::WORD_W:0]   trial;

  assign shifted   = {rem, quo[rau_pkg::WORD_W-1]};
  assign trial     = shifted - {1'b0, dvs};
  assign res.done  = done;
  assign res.value = {{rau_pkg::WORD_W{1'b0}}, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '1);
      if (op.start) begin
        busy <= 1'b1;
      end else if (cnt == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.start) begin
      rem <= '0;
      quo <= op.a;
      dvs <= op.b;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!trial[rau_pkg::WORD_W]) begin
        rem <= trial[rau_pkg::WORD_W-1:0];
        quo <= {quo[rau_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[rau_pkg::WORD_W-1:0];
        quo <= {quo[rau_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/rau_mul.sv
module rau_mul (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::unit_op_t op,
  output rau_pkg::unit_res_t res
);

  logic                       busy;
  logic                       done;
  logic [5:0]                 cnt;
  logic [rau_pkg::WORD_W-1:0] hi;
  logic [rau_pkg::WORD_W-1:0] lo;
  logic [rau_pkg::WORD_W-1:0] mc;
  logic [rau_pkg::WORD_W:0]   sum;

  assign sum       = {1'b0, hi} + {1'b0, (lo[0] ? mc : {rau_pkg::WORD_W{1'b0}})};
  assign res.done  = done;
  assign res.value = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '1);
      if (op.start) begin
        busy <= 1'b1;
      end else if (cnt == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.start) begin
      hi  <= '0;
      lo  <= op.b;
      mc  <= op.a;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      hi  <= sum[rau_pkg::WORD_W:1];
      lo  <= {sum[0], lo[rau_pkg::WORD_W-1:1]};
    end
  end

endmodule
